>>> design/fcbe_pkg.sv
// Shared types and constants of the flow counter bucket cache.
package fcbe_pkg;

  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS        = 16;
  localparam int SLOT_W      = 4;
  localparam int KEY_W       = 32;
  localparam int CNT_W       = 32;
  localparam int FILL_W      = 5;
  localparam int OUT_W       = 40;

  localparam logic [31:0] LRU_LIMIT = 32'h4000_0000;

  localparam logic [1:0] OUT_HIT    = 2'd0;
  localparam logic [1:0] OUT_INSERT = 2'd1;
  localparam logic [1:0] OUT_EVICT  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_WRITE
  } fcbe_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] stamp;
  } slot_ent_t;

endpackage

>>> design/flow_counter_bucket_evict.sv
// Top level: set-associative flow counter cache with round-robin or LRU eviction.
//
//  channel | dir | handshake              | payload
//  in      | in  | in_tvalid / in_tready  | in_tdata[31:0]  flow_id
//  out     | out | out_tvalid / out_tready| out_tdata[39:0] outcome, slot_used, evicted_key
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_data[0]     eviction_policy
//
// An item is taken in idle, then passes through the bucket remainder unit, the slot scan
// through the single read port of the slot memory and write-back; the next item is taken
// only once the last one has been written back and the sequencer is idle again.
// After reset a clearing pass writes every slot entry, one per cycle; no item is taken
// during it. A finished result waits in the output register; the next item is taken
// meanwhile, but its write-back holds until the output register is free.
module flow_counter_bucket_evict #(
  parameter int BUCKETS = fcbe_pkg::BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] flow_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] outcome, [5:2] slot_used, [37:6] evicted_key
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data    // [0] eviction_policy
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int AW    = BW + fcbe_pkg::SLOT_W;
  localparam int TOTAL = BUCKETS * fcbe_pkg::WAYS;
  localparam logic [AW-1:0] CLR_LAST = AW'(TOTAL - 1);

  fcbe_pkg::fcbe_state_t state_r, state_nxt;

  logic                   policy_r;
  logic [3:0]             rr_ptr_r;
  logic [31:0]            time_r;
  logic [31:0]            id_r;
  logic [BW-1:0]          bucket_r;
  logic [AW-1:0]          clr_cnt_r;
  logic [4:0]             scan_cnt_r;
  logic                   rd_vld_r;
  logic [3:0]             rd_slot_r;

  logic                   hit_r;
  logic [3:0]             hit_slot_r;
  logic [31:0]            hit_cnt_r;
  logic [31:0]            lru_min_r;
  logic [3:0]             lru_slot_r;
  logic [31:0]            lru_key_r;
  logic [31:0]            rr_key_r;

  logic                   out_tvalid_r;
  logic [39:0]            out_data_r;

  fcbe_pkg::slot_ent_t    slot_mem [TOTAL];
  logic [fcbe_pkg::FILL_W-1:0] fill_mem [BUCKETS];
  fcbe_pkg::slot_ent_t    rd_q;
  logic [fcbe_pkg::FILL_W-1:0] fill_q;

  logic                   mod_start;
  logic                   mod_done;
  logic [BW-1:0]          mod_rem;

  logic                   in_acc;
  logic                   commit;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  fcbe_pkg::slot_ent_t    wr_data;
  logic                   fill_we;
  logic [BW-1:0]          fill_waddr;
  logic [fcbe_pkg::FILL_W-1:0] fill_wdata;

  logic [1:0]             res_outcome;
  logic [3:0]             res_slot;
  logic [31:0]            res_evkey;
  logic [31:0]            res_cnt;

  fcbe_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_tdata),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcbe_pkg::ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) state_nxt = fcbe_pkg::ST_IDLE;
      end
      fcbe_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = fcbe_pkg::ST_MOD;
      end
      fcbe_pkg::ST_MOD: begin
        if (mod_done) state_nxt = fcbe_pkg::ST_SCAN;
      end
      fcbe_pkg::ST_SCAN: begin
        if (scan_cnt_r[4]) state_nxt = fcbe_pkg::ST_WRITE;
      end
      fcbe_pkg::ST_WRITE: begin
        if (!out_tvalid_r || out_tready) state_nxt = fcbe_pkg::ST_IDLE;
      end
      default: state_nxt = fcbe_pkg::ST_CLEAR;
    endcase
  end

  // result of the scan
  always_comb begin
    res_outcome = fcbe_pkg::OUT_HIT;
    res_slot    = hit_slot_r;
    res_evkey   = '0;
    res_cnt     = hit_cnt_r + 32'd1;
    if (!hit_r) begin
      res_cnt = 32'd1;
      if (!fill_q[4]) begin
        res_outcome = fcbe_pkg::OUT_INSERT;
        res_slot    = fill_q[3:0];
      end else begin
        res_outcome = fcbe_pkg::OUT_EVICT;
        res_slot    = policy_r ? lru_slot_r : rr_ptr_r;
        res_evkey   = policy_r ? lru_key_r : rr_key_r;
      end
    end
  end

  // outputs of the sequencer
  always_comb begin
    in_tready  = 1'b0;
    mod_start  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = {bucket_r, scan_cnt_r[3:0]};
    commit     = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = {bucket_r, res_slot};
    wr_data    = '{key: id_r, cnt: res_cnt, stamp: time_r};
    fill_we    = 1'b0;
    fill_waddr = bucket_r;
    fill_wdata = fill_q + 5'd1;
    case (state_r)
      fcbe_pkg::ST_CLEAR: begin
        wr_en      = 1'b1;
        wr_addr    = clr_cnt_r;
        wr_data    = '0;
        fill_we    = 1'b1;
        fill_waddr = clr_cnt_r[AW-1:fcbe_pkg::SLOT_W];
        fill_wdata = '0;
      end
      fcbe_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        mod_start = in_tvalid;
      end
      fcbe_pkg::ST_SCAN: begin
        rd_en = !scan_cnt_r[4];
      end
      fcbe_pkg::ST_WRITE: begin
        commit  = !out_tvalid_r || out_tready;
        wr_en   = commit;
        fill_we = commit && (res_outcome == fcbe_pkg::OUT_INSERT);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fcbe_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      policy_r     <= 1'b0;
      rr_ptr_r     <= '0;
      time_r       <= '0;
      scan_cnt_r   <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (state_r == fcbe_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cfg_valid && cfg_ready) policy_r <= cfg_data[0];
      if (in_acc) time_r <= time_r + 32'd1;
      if (state_r == fcbe_pkg::ST_MOD && mod_done) begin
        scan_cnt_r <= '0;
      end else if (state_r == fcbe_pkg::ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + 5'd1;
      end
      if (commit && !hit_r && fill_q[4] && !policy_r) rr_ptr_r <= rr_ptr_r + 4'd1;
      if (commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // item and scan datapath
  always_ff @(posedge clk) begin
    rd_slot_r <= scan_cnt_r[3:0];
    if (in_acc) id_r <= in_tdata;
    if (state_r == fcbe_pkg::ST_MOD && mod_done) begin
      bucket_r   <= mod_rem;
      hit_r      <= 1'b0;
      hit_slot_r <= '0;
      hit_cnt_r  <= '0;
      lru_min_r  <= fcbe_pkg::LRU_LIMIT;
      lru_slot_r <= '0;
      lru_key_r  <= '0;
      rr_key_r   <= '0;
    end else if (state_r == fcbe_pkg::ST_SCAN && rd_vld_r) begin
      if (!hit_r && rd_q.key == id_r) begin
        hit_r      <= 1'b1;
        hit_slot_r <= rd_slot_r;
        hit_cnt_r  <= rd_q.cnt;
      end
      if (rd_q.stamp < lru_min_r) begin
        lru_min_r  <= rd_q.stamp;
        lru_slot_r <= rd_slot_r;
        lru_key_r  <= rd_q.key;
      end else if (rd_slot_r == 4'd0) begin
        // slot 0 is the fallback victim when no stamp lies below the age limit
        lru_key_r <= rd_q.key;
      end
      if (rd_slot_r == rr_ptr_r) rr_key_r <= rd_q.key;
    end
    if (commit) out_data_r <= {2'b00, res_evkey, res_slot, res_outcome};
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= slot_mem[rd_addr];
  end

  // fill count memory
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_q <= fill_mem[bucket_r];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcbe_pkg::ST_CLEAR) |-> !in_tready)
    else $error("item taken during clearing pass");

  a_accept_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == fcbe_pkg::ST_MOD))
    else $error("accepted item did not start the remainder unit");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == fcbe_pkg::ST_MOD))
    else $error("remainder done outside of its state");

  a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_data_r[1:0] != fcbe_pkg::OUT_EVICT) |-> (out_data_r[37:6] == 32'd0))
    else $error("evicted key set without eviction");

  a_commit_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_tvalid_r || out_tready))
    else $error("result overwrote a pending transaction");
`endif

endmodule

>>> design/fcbe_mod.sv
// Bucket remainder unit: flow id modulo the bucket count by reciprocal multiplication.
module fcbe_mod #(
  parameter int BUCKETS = fcbe_pkg::BUCKETS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          dividend,
  output logic                 done,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] rem
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int L  = $clog2(BUCKETS);
  localparam logic [BW:0] BUCKETS_C = (BW + 1)'(BUCKETS);
  // ceil(2^(32+L) / BUCKETS) lies in [2^32, 2^33); only the low word is multiplied
  localparam longint unsigned RECIP =
    ((64'd1 << (32 + L)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [31:0] M_LO = 32'(RECIP - 64'h1_0000_0000);

  logic          busy_r;
  logic          done_r;
  logic [1:0]    step_r;
  logic [31:0]   x_r;
  logic [63:0]   p_r;
  logic [31:0]   q_r;
  logic [BW-1:0] rem_r;
  logic [32:0]   q_sum;
  logic [2*BW:0] qd;

  // quotient = (x + hi(x * M_LO)) >> L, exact for every 32-bit x
  assign q_sum = {1'b0, x_r} + {1'b0, p_r[63:32]};
  assign qd    = q_r[BW-1:0] * BUCKETS_C;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == 2'd2);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= dividend;
    end else if (busy_r) begin
      case (step_r)
        2'd0: begin
          p_r <= x_r * M_LO;
        end
        2'd1: begin
          q_r <= 32'(q_sum >> L);
        end
        2'd2: begin
          rem_r <= x_r[BW-1:0] - qd[BW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> dv/tb_flow_counter_bucket_evict.sv
// Self-checking testbench for the flow counter bucket cache: hit, insert and eviction results.
`timescale 1ns / 100ps

module tb_flow_counter_bucket_evict;

  localparam int unsigned BUCKETS     = fcbe_pkg::BUCKETS_DEF;
  localparam int unsigned TAGS        = 24;
  localparam int unsigned HOT_BUCKETS = 8;
  localparam int          QUIET_LIMIT = 80000;
  localparam int          HOLD_CYCLES = 600;
  localparam int          DRAIN_WAIT  = 60;

  typedef struct {
    logic [1:0]  outcome;
    logic [3:0]  slot;
    logic [31:0] evicted_key;
  } flow_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] flow_id
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [1:0] outcome, [5:2] slot_used, [37:6] evicted_key
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data   = '0;   // [0] eviction_policy

  // shadow copy of the cache contents
  bit [31:0] key_mem   [BUCKETS*fcbe_pkg::WAYS];
  bit [31:0] cnt_mem   [BUCKETS*fcbe_pkg::WAYS];
  bit [31:0] stamp_mem [BUCKETS*fcbe_pkg::WAYS];
  bit [4:0]  fill_mem  [BUCKETS];
  bit [3:0]  rr_ptr;
  bit [31:0] access_tick;
  bit        evict_lru;

  logic [31:0]  flow_id_q [$];
  flow_result_t flow_expect_q [$];
  flow_result_t want;
  int           items_queued;
  int           items_taken;
  int           err_cnt;
  int           quiet_cycles;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           holding;

  logic [9:0]  hot_bucket [HOT_BUCKETS];
  logic [21:0] tag_pool   [TAGS];

  flow_counter_bucket_evict i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic flow_result_t cache_access(input logic [31:0] id);
    int unsigned  bucket;
    int unsigned  base;
    int unsigned  fill;
    int unsigned  victim;
    logic [31:0]  oldest;
    flow_result_t r;
    bucket = id % BUCKETS;
    base   = bucket * fcbe_pkg::WAYS;
    access_tick = access_tick + 32'd1;
    for (int s = 0; s < fcbe_pkg::WAYS; s++) begin
      if (key_mem[base+s] == id) begin
        cnt_mem[base+s]   = cnt_mem[base+s] + 32'd1;
        stamp_mem[base+s] = access_tick;
        r.outcome     = fcbe_pkg::OUT_HIT;
        r.slot        = 4'(s);
        r.evicted_key = '0;
        return r;
      end
    end
    fill = 32'(fill_mem[bucket]);
    if (fill < fcbe_pkg::WAYS) begin
      key_mem[base+fill]   = id;
      cnt_mem[base+fill]   = 1;
      stamp_mem[base+fill] = access_tick;
      fill_mem[bucket]     = 5'(fill + 1);
      r.outcome     = fcbe_pkg::OUT_INSERT;
      r.slot        = 4'(fill);
      r.evicted_key = '0;
      return r;
    end
    if (evict_lru) begin
      // first strictly oldest stamp below the age limit, slot 0 if none
      victim = 0;
      oldest = fcbe_pkg::LRU_LIMIT;
      for (int s = 0; s < fcbe_pkg::WAYS; s++) begin
        if (stamp_mem[base+s] < oldest) begin
          oldest = stamp_mem[base+s];
          victim = s;
        end
      end
    end else begin
      victim = 32'(rr_ptr);
      rr_ptr = rr_ptr + 4'd1;
    end
    r.outcome     = fcbe_pkg::OUT_EVICT;
    r.slot        = 4'(victim);
    r.evicted_key = key_mem[base+victim];
    key_mem[base+victim]   = id;
    cnt_mem[base+victim]   = 1;
    stamp_mem[base+victim] = access_tick;
    return r;
  endfunction

  // mostly a few hot buckets with a small tag pool, so buckets overflow and ids repeat
  function automatic logic [31:0] pick_flow_id();
    int unsigned roll;
    int unsigned tag_idx;
    logic [9:0]  b;
    roll = $urandom_range(99);
    if (roll < 2) return '0;
    if (roll < 14) return $urandom;
    b = hot_bucket[$urandom_range(HOT_BUCKETS-1)];
    tag_idx = (roll < 60) ? $urandom_range(5) : $urandom_range(TAGS-1);
    return {tag_pool[tag_idx], b};
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 100) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic write_policy(input bit lru);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lru;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    evict_lru = lru;
  endtask

  task automatic push_flow(input logic [31:0] id);
    flow_id_q.push_back(id);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || flow_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input bit lru, input int send_pct, input int recv_pct,
                           input int n_items, input bit squeeze);
    write_policy(lru);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) begin
      fork
        begin
          @(posedge clk);
          holding <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          holding <= 1'b0;
        end
      join_none
    end
    for (int i = 0; i < n_items; i++) push_flow(pick_flow_id());
    wait_drained();
  endtask

  // input driver: one transaction per accepted flow id
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        flow_expect_q.push_back(cache_access(in_tdata));
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (flow_id_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= flow_id_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (flow_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = flow_expect_q.pop_front();
        if (out_tdata[1:0] !== want.outcome)
          report_mismatch($sformatf("outcome %0d, want %0d", out_tdata[1:0], want.outcome));
        if (out_tdata[5:2] !== want.slot)
          report_mismatch($sformatf("slot_used %0d, want %0d", out_tdata[5:2], want.slot));
        if (out_tdata[37:6] !== want.evicted_key)
          report_mismatch($sformatf("evicted_key %h, want %h", out_tdata[37:6],
                                    want.evicted_key));
      end
    end
    out_tready <= rst_n && !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_flow_counter_bucket_evict: errors");
      $finish;
    end
  end

  initial begin
    hot_bucket[0] = '0;
    for (int i = 1; i < HOT_BUCKETS; i++) hot_bucket[i] = 10'($urandom_range(BUCKETS-1));
    tag_pool[0] = '0;
    for (int i = 1; i < TAGS; i++) tag_pool[i] = 22'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-slot hits in bucket 0, top id, then overflow of one bucket
    write_policy(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_flow(32'h0000_0000);
    push_flow(32'h0000_0000);
    push_flow(32'hFFFF_FFFF);
    push_flow(32'h0000_0400);  // bucket 0 miss lands on slot 0 over the zero key
    push_flow(32'h0000_0000);  // now hits slot 1
    for (int k = 0; k <= 16; k++) push_flow(32'(5 + k * BUCKETS));
    push_flow(32'h0000_0005);  // evicted a moment ago, evicts again
    wait_drained();

    run_phase(1'b0, 0, 0, 300, 1'b0);
    run_phase(1'b1, 76, 0, 300, 1'b0);
    run_phase(1'b1, 0, 76, 300, 1'b1);
    run_phase(1'b0, 6, 6, 300, 1'b0);
    run_phase(1'b1, 0, 0, 300, 1'b0);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0 && flow_expect_q.size() == 0)
      $display("tb_flow_counter_bucket_evict: clean");
    else
      $display("tb_flow_counter_bucket_evict: errors");
    $finish;
  end

endmodule

>>> files.f
design/fcbe_pkg.sv
design/fcbe_mod.sv
design/flow_counter_bucket_evict.sv
dv/tb_flow_counter_bucket_evict.sv
